[hw/rtl/dtok_pkg.sv]
// Shared types and constants for the delimiter tokenizer.
package dtok_pkg;

	// tokenizer phase codes
	localparam logic [1:0] PH_BEGIN = 2'd0;
	localparam logic [1:0] PH_TOKEN = 2'd1;
	localparam logic [1:0] PH_DELIM = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_TOKEN = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;
	localparam logic [1:0] KIND_SUM   = 2'd2;

	// register indexes
	localparam logic [1:0] REG_DELIM_CHARS = 2'd0;
	localparam logic [1:0] REG_DELIM_COUNT = 2'd1;
	localparam logic [1:0] REG_KEEP_EMPTY  = 2'd2;
	localparam logic [1:0] REG_MAX_TOKENS  = 2'd3;

	// register reset values: ',' ';' ' '
	localparam logic [63:0] RST_DELIM_CHARS = 64'h0000_0000_0020_3B2C;
	localparam logic [3:0]  RST_DELIM_COUNT = 4'd3;
	localparam logic        RST_KEEP_EMPTY  = 1'b0;
	localparam logic [6:0]  RST_MAX_TOKENS  = 7'd64;

	typedef struct packed {
		logic [63:0] delim_chars;
		logic [3:0]  delim_count;
		logic        keep_empty;
		logic [6:0]  max_tokens;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [5:0]  index;
		logic [15:0] start;
		logic [15:0] length;
		logic [6:0]  total;
		logic        last;
	} res_t;

	// up to two results per byte; n1 only with n0
	typedef struct packed {
		logic n0;
		logic n1;
		res_t r0;
		res_t r1;
	} res_pair_t;

endpackage

[hw/rtl/dtok_match.sv]
// Parallel compare of one byte against the configured delimiter bytes.
module dtok_match import dtok_pkg::*; #(
	parameter int MAX_DELIMS = 8
) (
	input  logic [63:0] delim_chars,
	input  logic [3:0]  delim_count,
	input  logic [7:0]  char_byte,
	output logic        hit
);

	localparam logic [3:0] DELIM_CAP = 4'(MAX_DELIMS);

	logic [3:0] n_use;

	always_comb begin
		n_use = (delim_count > DELIM_CAP) ? DELIM_CAP : delim_count;
		hit   = 1'b0;
		for (int j = 0; j < MAX_DELIMS; j++) begin
			if ((4'(j) < n_use) && (delim_chars[8*j +: 8] == char_byte))
				hit = 1'b1;
		end
	end

endmodule

[hw/rtl/dtok_core.sv]
// Tokenizer state and per-byte result generation.
module dtok_core import dtok_pkg::*; #(
	parameter int MAX_TOKENS  = 64,
	parameter int MAX_DELIMS  = 8,
	parameter int OFFSET_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       fire,
	input  logic [7:0] char_byte,
	input  logic       eom,
	output res_pair_t  res
);

	localparam logic [OFFSET_BITS-1:0] OFFS_MAX = '1;
	localparam logic [OFFSET_BITS-1:0] OFFS_ONE = OFFSET_BITS'(1);
	localparam logic [8:0]             TOK_CAP  = 9'(MAX_TOKENS);

	logic [1:0]             phase_q,  phase_d;
	logic [OFFSET_BITS-1:0] offs_q,   offs_d;
	logic [OFFSET_BITS-1:0] start_q,  start_d;
	logic [OFFSET_BITS-1:0] len_q,    len_d;
	logic [6:0]             count_q,  count_d;
	logic                   limit_q,  limit_d;

	logic       hit;
	logic [6:0] lim;
	logic       at_lim;
	logic       av, bv;
	res_t       ra, rb, rc;

	dtok_match #(.MAX_DELIMS(MAX_DELIMS)) u_match (
		.delim_chars (cfg.delim_chars),
		.delim_count (cfg.delim_count),
		.char_byte   (char_byte),
		.hit         (hit)
	);

	always_comb begin
		lim    = ({2'b00, cfg.max_tokens} > TOK_CAP) ? TOK_CAP[6:0] : cfg.max_tokens;
		at_lim = (count_q >= lim);

		phase_d = phase_q;
		start_d = start_q;
		len_d   = len_q;
		count_d = count_q;
		limit_d = limit_q;

		av = 1'b0;
		ra = '0;

		if (!limit_q) begin
			if (hit) begin
				if (phase_q == PH_TOKEN) begin
					av        = 1'b1;
					ra.kind   = KIND_TOKEN;
					ra.index  = 6'(count_q - 7'd1);
					ra.start  = 16'(start_q);
					ra.length = 16'(len_q);
				end else if ((phase_q == PH_DELIM) && cfg.keep_empty) begin
					if (at_lim) begin
						limit_d = 1'b1;
					end else begin
						av       = 1'b1;
						ra.kind  = KIND_EMPTY;
						ra.index = 6'(count_q);
						count_d  = count_q + 7'd1;
					end
				end
				phase_d = PH_DELIM;
			end else if (phase_q == PH_TOKEN) begin
				if (len_q != OFFS_MAX)
					len_d = len_q + OFFS_ONE;
			end else if (at_lim) begin
				limit_d = 1'b1;
			end else begin
				start_d = offs_q;
				len_d   = OFFS_ONE;
				count_d = count_q + 7'd1;
				phase_d = PH_TOKEN;
			end
		end

		offs_d = (offs_q != OFFS_MAX) ? offs_q + OFFS_ONE : offs_q;

		// token still open at the last byte
		bv        = eom && (phase_d == PH_TOKEN) && !limit_d;
		rb        = '0;
		rb.kind   = KIND_TOKEN;
		rb.index  = 6'(count_d - 7'd1);
		rb.start  = 16'(start_d);
		rb.length = 16'(len_d);

		rc       = '0;
		rc.kind  = KIND_SUM;
		rc.total = count_d;
		rc.last  = 1'b1;

		// a closing delimiter and an open token at end cannot both occur
		res.n0 = av || bv || eom;
		res.n1 = (av || bv) && eom;
		res.r0 = av ? ra : (bv ? rb : rc);
		res.r0.last = !res.n1;
		res.r1 = rc;

		if (eom) begin
			phase_d = PH_BEGIN;
			offs_d  = '0;
			start_d = '0;
			len_d   = '0;
			count_d = '0;
			limit_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BEGIN;
			offs_q  <= '0;
			start_q <= '0;
			len_q   <= '0;
			count_q <= '0;
			limit_q <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			offs_q  <= offs_d;
			start_q <= start_d;
			len_q   <= len_d;
			count_q <= count_d;
			limit_q <= limit_d;
		end
	end

endmodule

[hw/rtl/dtok_out.sv]
// Result register with one pending slot for the second result of a byte.
module dtok_out import dtok_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  res_pair_t res,
	input  logic      m_tready,
	output logic      free,
	output logic      out_valid,
	output res_t      out_res
);

	logic out_valid_q;
	logic pend_valid_q;
	res_t out_q;
	res_t pend_q;

	assign free      = !pend_valid_q && (!out_valid_q || m_tready);
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q  <= res.n0;
			pend_valid_q <= res.n1;
		end else if (out_valid_q && m_tready) begin
			out_valid_q  <= pend_valid_q;
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q  <= res.r0;
			pend_q <= res.r1;
		end else if (out_valid_q && m_tready) begin
			out_q <= pend_q;
		end
	end

endmodule

[hw/rtl/delimiter_tokenizer.sv]
// Top level of the delimiter tokenizer: input register, config registers, core, output.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata[7:0] char_byte, s_tlast end_of_message
//  m_*      out  m_tvalid/m_tready  m_tdata index/start/length/total, m_tuser kind,
//                                   m_tlast final_res
//  cfg_*    in   cfg_we             cfg_index register, cfg_data value
//
// One byte per cycle while the output has room: a byte waits in the input register, is
// classified by the parallel delimiter compare and the state update, and its first
// result lands in the output register. A byte giving two results (token close plus
// summary) fills the pending slot and holds the next byte back while it drains.
// Reset clears the tokenizer state, the valid flags and loads the default config.
// A stalled sink backs up through the output register into the input register.
module delimiter_tokenizer import dtok_pkg::*; #(
	parameter int MAX_TOKENS  = 64,
	parameter int MAX_DELIMS  = 8,
	parameter int OFFSET_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_byte
	input  logic        s_tlast,   // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [5:0] token_index, [21:6] token_start,
	                               // [37:22] token_length, [44:38] token_total, rest 0
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast,   // final_res
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eom_s1;
	logic       out_free;
	logic       fire;
	res_pair_t  res;
	logic       out_valid;
	res_t       out_res;

	// config registers; the user must write them only while idle (the block does not check)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delim_chars <= RST_DELIM_CHARS;
			cfg_q.delim_count <= RST_DELIM_COUNT;
			cfg_q.keep_empty  <= RST_KEEP_EMPTY;
			cfg_q.max_tokens  <= RST_MAX_TOKENS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DELIM_CHARS: cfg_q.delim_chars <= cfg_data;
				REG_DELIM_COUNT: cfg_q.delim_count <= cfg_data[3:0];
				REG_KEEP_EMPTY:  cfg_q.keep_empty  <= cfg_data[0];
				REG_MAX_TOKENS:  cfg_q.max_tokens  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// input register; byte moves on when the output side has room
	assign fire     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eom_s1  <= s_tlast;
		end
	end

	dtok_core #(
		.MAX_TOKENS  (MAX_TOKENS),
		.MAX_DELIMS  (MAX_DELIMS),
		.OFFSET_BITS (OFFSET_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.fire      (fire),
		.char_byte (byte_s1),
		.eom       (eom_s1),
		.res       (res)
	);

	dtok_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.res       (res),
		.m_tready  (m_tready),
		.free      (out_free),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	assign m_tvalid = out_valid;
	assign m_tdata  = {3'b000, out_res.total, out_res.length, out_res.start, out_res.index};
	assign m_tuser  = out_res.kind;
	assign m_tlast  = out_res.last;

`ifndef SYNTH
	// a held byte stays put until the core takes it
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1 && $stable(byte_s1) && $stable(eom_s1))
		else $error("input register lost or changed a waiting byte");

	// the summary is always the last result of its byte
	a_sum_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_SUM) |-> m_tlast)
		else $error("summary result not marked last");

	// while a first result of two is shown, its second blocks the next byte
	a_pair_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !fire)
		else $error("new byte processed while a result pair is unfinished");
`endif

endmodule

[verif/testbench.sv]
// Self-checking testbench for the delimiter tokenizer: stream stimulus, token predictor, scoreboard.
`timescale 1ns / 100ps

module testbench;
	import dtok_pkg::*;

	localparam int            DELIM_SLOTS = 8;         // parallel compare width of the block
	localparam logic [6:0]    TOKEN_CAP   = 7'd64;     // hard token ceiling per message
	localparam logic [15:0]   OFFSET_SAT  = 16'hFFFF;  // offset and length saturate here
	localparam int            RAND_PHASES = 8;
	localparam int            PHASE_ITEMS = 100;
	localparam int            LONG_RUN    = 70;        // more tokens than the ceiling allows
	localparam int            SETTLE_CYC  = 8;

	// one byte of a message as it goes onto the slave stream
	typedef struct packed {
		logic [7:0] ch;
		logic       eom;
	} msg_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;    // [7:0] char_byte
	logic        s_tlast = 1'b0;    // end_of_message
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;           // [5:0] index, [21:6] start, [37:22] length, [44:38] total
	logic [1:0]  m_tuser;           // [1:0] kind
	logic        m_tlast;           // final_res
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_DELIM_CHARS;
	logic [63:0] cfg_data = 64'd0;

	delimiter_tokenizer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// ---------------------------------------------------------------------------------
	// Shadow copy of the register file, kept in step with every write we issue
	// ---------------------------------------------------------------------------------
	logic [63:0] sh_delims   = RST_DELIM_CHARS;
	logic [3:0]  sh_ndelim   = RST_DELIM_COUNT;
	logic        sh_keep     = RST_KEEP_EMPTY;
	logic [6:0]  sh_maxtok   = RST_MAX_TOKENS;

	// tokenizer state as the predictor sees it
	logic [1:0]  tk_phase    = PH_BEGIN;
	logic [15:0] tk_offset   = 16'd0;
	logic [15:0] tk_start    = 16'd0;
	logic [15:0] tk_len      = 16'd0;
	logic [6:0]  tk_count    = 7'd0;
	logic        tk_stopped  = 1'b0;   // token limit hit, rest of message ignored

	msg_byte_t   pending_bytes[$];     // items waiting for the driver
	res_t        expected_tokens[$];   // predicted results, oldest first

	int          src_idle_pct  = 0;
	int          snk_stall_pct = 0;
	logic        in_taken = 1'b0;      // slave item accepted at the last rising edge
	msg_byte_t   drv_byte;
	res_t        seen_res;
	res_t        due_res;

	int          mismatches    = 0;
	int          bytes_in      = 0;
	int          n_tokens      = 0;
	int          n_empty       = 0;
	int          n_summaries   = 0;
	int          n_settings    = 1;    // reset values count as the first

	// ---------------------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------------------
	function automatic bit delim_hit(logic [7:0] b);
		int n;
		n = (sh_ndelim > DELIM_SLOTS) ? DELIM_SLOTS : int'(sh_ndelim);
		for (int j = 0; j < n; j++)
			if (sh_delims[8*j +: 8] == b)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic res_t make_res(logic [1:0] k, logic [5:0] idx, logic [15:0] st,
	                                  logic [15:0] ln, logic [6:0] tot);
		res_t r;
		r.kind   = k;
		r.index  = idx;
		r.start  = st;
		r.length = ln;
		r.total  = tot;
		r.last   = 1'b0;
		return r;
	endfunction

	// Advance the tokenizer by one byte and queue whatever results it gives.
	function automatic void tokenize_byte(logic [7:0] b, logic eom);
		res_t       outs[2];
		int         n;
		logic [6:0] limit;
		n = 0;
		limit = (sh_maxtok > TOKEN_CAP) ? TOKEN_CAP : sh_maxtok;

		if (!tk_stopped) begin
			if (delim_hit(b)) begin
				if (tk_phase == PH_TOKEN) begin
					outs[n] = make_res(KIND_TOKEN, 6'(tk_count - 7'd1), tk_start, tk_len, 7'd0);
					n++;
				end else if (tk_phase == PH_DELIM && sh_keep) begin
					// back-to-back delimiters: empty token, unless the limit is full
					if (tk_count >= limit) begin
						tk_stopped = 1'b1;
					end else begin
						outs[n] = make_res(KIND_EMPTY, 6'(tk_count), 16'd0, 16'd0, 7'd0);
						n++;
						tk_count++;
					end
				end
				tk_phase = PH_DELIM;
			end else if (tk_phase == PH_TOKEN) begin
				if (tk_len != OFFSET_SAT)
					tk_len++;
			end else if (tk_count >= limit) begin
				tk_stopped = 1'b1;
			end else begin
				tk_start = tk_offset;
				tk_len   = 16'd1;
				tk_count++;
				tk_phase = PH_TOKEN;
			end
		end

		if (tk_offset != OFFSET_SAT)
			tk_offset++;

		if (eom) begin
			// close any open token, then the summary; state back to start of message
			if (tk_phase == PH_TOKEN && !tk_stopped) begin
				outs[n] = make_res(KIND_TOKEN, 6'(tk_count - 7'd1), tk_start, tk_len, 7'd0);
				n++;
			end
			outs[n] = make_res(KIND_SUM, 6'd0, 16'd0, 16'd0, tk_count);
			n++;
			tk_phase   = PH_BEGIN;
			tk_offset  = 16'd0;
			tk_start   = 16'd0;
			tk_len     = 16'd0;
			tk_count   = 7'd0;
			tk_stopped = 1'b0;
		end

		if (n > 0)
			outs[n-1].last = 1'b1;
		for (int k = 0; k < n; k++)
			expected_tokens.push_back(outs[k]);
	endfunction

	function automatic string res_text(res_t r);
		return $sformatf("kind %0d idx %0d start %0d len %0d total %0d last %0d",
		                 r.kind, r.index, r.start, r.length, r.total, r.last);
	endfunction

	// ---------------------------------------------------------------------------------
	// Slave side: driver at the falling edge, acceptance and prediction at the rising
	// ---------------------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_taken) begin
			if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
				drv_byte = pending_bytes.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= drv_byte.ch;
				s_tlast  <= drv_byte.eom;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				tokenize_byte(s_tdata, s_tlast);
				bytes_in++;
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Master side: random back-pressure, results checked against the oldest prediction
	// ---------------------------------------------------------------------------------
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_res.kind   = m_tuser;
			seen_res.index  = m_tdata[5:0];
			seen_res.start  = m_tdata[21:6];
			seen_res.length = m_tdata[37:22];
			seen_res.total  = m_tdata[44:38];
			seen_res.last   = m_tlast;
			if (expected_tokens.size() == 0) begin
				mismatches++;
				$display("%0t: result with nothing expected: got %s", $time, res_text(seen_res));
			end else begin
				due_res = expected_tokens.pop_front();
				if (seen_res !== due_res) begin
					mismatches++;
					$display("%0t: expected %s", $time, res_text(due_res));
					$display("%0t:      got %s", $time, res_text(seen_res));
				end
				case (due_res.kind)
					KIND_TOKEN: n_tokens++;
					KIND_EMPTY: n_empty++;
					default:    n_summaries++;
				endcase
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------------------
	task automatic write_reg(logic [1:0] idx, logic [63:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_DELIM_CHARS: sh_delims = val;
			REG_DELIM_COUNT: sh_ndelim = val[3:0];
			REG_KEEP_EMPTY:  sh_keep   = val[0];
			default:         sh_maxtok = val[6:0];
		endcase
	endtask

	task automatic apply_setting(logic [63:0] chars, logic [3:0] cnt, logic keep,
	                             logic [6:0] maxt);
		write_reg(REG_DELIM_CHARS, chars);
		write_reg(REG_DELIM_COUNT, 64'(cnt));
		write_reg(REG_KEEP_EMPTY, 64'(keep));
		write_reg(REG_MAX_TOKENS, 64'(maxt));
		n_settings++;
	endtask

	task automatic add_byte(logic [7:0] b, logic eom);
		msg_byte_t mb;
		mb.ch  = b;
		mb.eom = eom;
		pending_bytes.push_back(mb);
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i], i == s.len() - 1);
	endtask

	// Short message, delimiter-heavy so runs of delimiters and the limit both get hit.
	task automatic add_random_msg(output int len);
		int n;
		int j;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
		for (int i = 0; i < n; i++) begin
			if (sh_ndelim != 0 && $urandom_range(0, 99) < 35) begin
				j = $urandom_range(0, ((sh_ndelim > DELIM_SLOTS) ? DELIM_SLOTS : sh_ndelim) - 1);
				add_byte(sh_delims[8*j +: 8], i == n - 1);
			end else begin
				add_byte(8'($urandom_range(0, 255)), i == n - 1);
			end
		end
		len = n;
	endtask

	task automatic set_idling(int mode);
		case (mode)
			0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
			1: begin src_idle_pct = 62; snk_stall_pct = 0;  end
			2: begin src_idle_pct = 0;  snk_stall_pct = 62; end
			default: begin src_idle_pct = 27; snk_stall_pct = 27; end
		endcase
	endtask

	// Everything sent, every result back, then a settling wait for a byte with no result.
	task automatic settle();
		while (pending_bytes.size() != 0 || s_tvalid || expected_tokens.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// ---------------------------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------------------------
	initial begin
		logic [63:0] chars;
		logic [3:0]  cnt;
		logic [6:0]  maxt;
		int          got_len;
		int          phase_items;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: ',' ';' ' ', no empty tokens, limit 64
		set_idling(0);
		add_text("a");               // single-byte token plus summary from one byte
		add_text(",");               // leading delimiter records no token, only the summary
		add_text("ab,c d;;e");
		add_byte(8'h00, 1'b0);
		add_byte(8'hFF, 1'b1);
		settle();

		// count above the compare width, all-ones and zero delimiters, limit of two
		apply_setting(64'hFF00_7C2E_3A2D_2B2C, 4'd9, 1'b1, 7'd2);
		add_byte(",", 1'b0);         // leading delimiter
		add_byte(",", 1'b0);         // empty token
		add_byte("x", 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'hFF, 1'b0);       // empty token over the limit: rest ignored
		add_byte("y", 1'b1);
		add_byte("a", 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte("b", 1'b0);         // token opened at the limit keeps growing
		add_byte("c", 1'b1);
		settle();

		// limit zero: summary only
		apply_setting(RST_DELIM_CHARS, RST_DELIM_COUNT, 1'b1, 7'd0);
		add_text("ab,,c");
		settle();

		// limit above the ceiling, with more tokens in the message than the ceiling
		apply_setting(RST_DELIM_CHARS, RST_DELIM_COUNT, 1'b0, 7'd127);
		for (int i = 0; i < LONG_RUN; i++) begin
			add_byte("a", 1'b0);
			add_byte(",", 1'b0);
		end
		add_text(",b");
		settle();

		// random phases, cycling through the idling patterns
		for (int p = 0; p < RAND_PHASES; p++) begin
			chars = ($urandom_range(0, 3) == 0) ? RST_DELIM_CHARS : {$urandom, $urandom};
			case (p)
				0: begin cnt = 4'd8;  maxt = 7'd127; end
				1: begin cnt = 4'd15; maxt = 7'd1;   end
				2: begin cnt = 4'd0;  maxt = 7'd64;  end
				3: begin cnt = 4'd1;  maxt = 7'd0;   end
				default: begin
					cnt  = 4'($urandom_range(0, 15));
					maxt = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(1, 6))
					                                    : 7'($urandom_range(0, 127));
				end
			endcase
			apply_setting(chars, cnt, (p % 3) != 0, maxt);
			set_idling(p % 4);
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				add_random_msg(got_len);
				phase_items += got_len;
			end
			settle();
		end

		if (expected_tokens.size() != 0) begin
			mismatches += expected_tokens.size();
			$display("%0t: %0d results never arrived", $time, expected_tokens.size());
		end

		$display("Sent %0d bytes under %0d register settings and four idling patterns.",
		         bytes_in, n_settings);
		$display("Checked %0d tokens, %0d empty tokens and %0d message summaries.",
		         n_tokens, n_empty, n_summaries);
		if (mismatches == 0) begin
			$display("delimiter_tokenizer: match");
		end else begin
			$display("delimiter_tokenizer: mismatch");
		end
		$finish;
	end

	// watchdog
	initial begin
		#200_000;
		$display("Timed out with %0d items unsent, %0d results outstanding.",
		         pending_bytes.size(), expected_tokens.size());
		$display("delimiter_tokenizer: mismatch");
		$finish;
	end

endmodule
